FILE: hw/rtl/lfcr_pkg.sv
// Types, register indexes and reset values for the LED flash current regulator.
package lfcr_pkg;

	localparam int unsigned CUR_W   = 10;
	localparam int unsigned WIDTH_W = 8;
	localparam int unsigned DIV_W   = 8;
	localparam int unsigned TIME_W  = 16;
	localparam int unsigned CYC_W   = 8;
	localparam int unsigned REG_IDX_W  = 3;
	localparam int unsigned REG_DATA_W = 16;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TARGET_CURRENT = 3'd0,
		REG_WIDTH_START    = 3'd1,
		REG_WIDTH_FLOOR    = 3'd2,
		REG_WIDTH_CEILING  = 3'd3,
		REG_TICKS_PER_MS   = 3'd4,
		REG_ON_TIME_MS     = 3'd5,
		REG_OFF_TIME_MS    = 3'd6,
		REG_MIN_CYCLES     = 3'd7
	} reg_idx_t;

	localparam logic [CUR_W-1:0]   TARGET_CURRENT_RST = 10'd730;
	localparam logic [WIDTH_W-1:0] WIDTH_START_RST    = 8'd150;
	localparam logic [WIDTH_W-1:0] WIDTH_FLOOR_RST    = 8'd80;
	localparam logic [WIDTH_W-1:0] WIDTH_CEILING_RST  = 8'd200;
	localparam logic [DIV_W-1:0]   TICKS_PER_MS_RST   = 8'd25;
	localparam logic [TIME_W-1:0]  ON_TIME_MS_RST     = 16'd50;
	localparam logic [TIME_W-1:0]  OFF_TIME_MS_RST    = 16'd950;
	localparam logic [CYC_W-1:0]   MIN_CYCLES_RST     = 8'd3;

	typedef enum logic [3:0] {
		SEQ_INIT    = 4'b0001,
		SEQ_PREPARE = 4'b0010,
		SEQ_ON      = 4'b0100,
		SEQ_OFF     = 4'b1000
	} seq_state_t;

endpackage

FILE: hw/rtl/lfcr_if.sv
// Tick and result channel interfaces.
interface lfcr_tick_if
	import lfcr_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CUR_W-1:0] current_ma;
	logic             switch_off;

	modport source (output valid, output current_ma, output switch_off, input ready);
	modport sink (input valid, input current_ma, input switch_off, output ready);
endinterface

interface lfcr_result_if
	import lfcr_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               pulse_start;
	logic [WIDTH_W-1:0] pulse_width;
	logic               led_phase_on;
	logic               asleep;

	modport source (output valid, output pulse_start, output pulse_width,
		output led_phase_on, output asleep, input ready);
	modport sink (input valid, input pulse_start, input pulse_width,
		input led_phase_on, input asleep, output ready);
endinterface

FILE: hw/rtl/led_flash_current_regulator.sv
// LED flash current regulator: width regulation, ms divider and flash sequencer.
//
//  channel  dir  payload                                          transaction
//  tick     in   current_ma[9:0], switch_off                      valid & ready
//  result   out  pulse_start, pulse_width[7:0], led_phase_on,     valid & ready
//                asleep
//  wr_*     in   wr_index[2:0], wr_data[15:0]                     wr_en
//
// One tick per cycle unless result stalls; path: input register, then result register.
// The tick state update sits between those two registers in one combinational pass.
// Reset loads the register defaults and clears the sequencer; no clearing pass.
// A stalled result holds the result register; the input register then fills and
// tick.ready drops in the same cycle.
module led_flash_current_regulator
	import lfcr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	lfcr_tick_if.sink             tick,
	lfcr_result_if.source         result,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [REG_DATA_W-1:0] wr_data
);

	// configuration registers
	logic [CUR_W-1:0]   target_current_q;
	logic [WIDTH_W-1:0] width_start_q, width_floor_q, width_ceiling_q;
	logic [DIV_W-1:0]   ticks_per_ms_q;
	logic [TIME_W-1:0]  on_time_ms_q, off_time_ms_q;
	logic [CYC_W-1:0]   min_cycles_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_current_q <= TARGET_CURRENT_RST;
			width_start_q    <= WIDTH_START_RST;
			width_floor_q    <= WIDTH_FLOOR_RST;
			width_ceiling_q  <= WIDTH_CEILING_RST;
			ticks_per_ms_q   <= TICKS_PER_MS_RST;
			on_time_ms_q     <= ON_TIME_MS_RST;
			off_time_ms_q    <= OFF_TIME_MS_RST;
			min_cycles_q     <= MIN_CYCLES_RST;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_TARGET_CURRENT: target_current_q <= wr_data[CUR_W-1:0];
				REG_WIDTH_START:    width_start_q    <= wr_data[WIDTH_W-1:0];
				REG_WIDTH_FLOOR:    width_floor_q    <= wr_data[WIDTH_W-1:0];
				REG_WIDTH_CEILING:  width_ceiling_q  <= wr_data[WIDTH_W-1:0];
				REG_TICKS_PER_MS:   ticks_per_ms_q   <= wr_data[DIV_W-1:0];
				REG_ON_TIME_MS:     on_time_ms_q     <= wr_data[TIME_W-1:0];
				REG_OFF_TIME_MS:    off_time_ms_q    <= wr_data[TIME_W-1:0];
				REG_MIN_CYCLES:     min_cycles_q     <= wr_data[CYC_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake and pipeline control
	logic             valid_s1;
	logic [CUR_W-1:0] current_ma_s1;
	logic             switch_off_s1;
	logic             valid_s2;
	logic             advance;

	assign advance    = !valid_s2 || result.ready;
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			current_ma_s1 <= tick.current_ma;
			switch_off_s1 <= tick.switch_off;
		end
	end

	// regulator state
	logic               booster_on_q, booster_on_d;
	logic [WIDTH_W-1:0] width_now_q, width_now_d;
	logic [DIV_W-1:0]   ms_divider_q, ms_divider_d;
	logic [TIME_W-1:0]  phase_timer_q, phase_timer_d;
	seq_state_t         seq_q, seq_d;
	logic [CYC_W-1:0]   cycles_left_q, cycles_left_d;
	logic               sleeping_q, sleeping_d;

	logic               start;
	logic [WIDTH_W-1:0] width_reg;
	logic               ms_ev;
	logic [DIV_W-1:0]   div_base;
	logic [TIME_W-1:0]  timer_dec;

	always_comb begin
		booster_on_d  = booster_on_q;
		width_now_d   = width_now_q;
		ms_divider_d  = ms_divider_q;
		phase_timer_d = phase_timer_q;
		seq_d         = seq_q;
		cycles_left_d = cycles_left_q;
		sleeping_d    = sleeping_q;
		start         = 1'b0;
		width_reg     = width_now_q;
		ms_ev         = (ms_divider_q == '0);
		div_base      = ms_ev ? ticks_per_ms_q : ms_divider_q;
		timer_dec     = (phase_timer_q != '0) ? phase_timer_q - 1'b1 : phase_timer_q;

		if (sleeping_q) begin
			// a tick with the switch on wakes up and finishes the deferred off-phase check
			if (!switch_off_s1) begin
				sleeping_d    = 1'b0;
				cycles_left_d = min_cycles_q;
				if (phase_timer_q == '0) begin
					seq_d = SEQ_PREPARE;
				end
			end
		end else begin
			if (booster_on_q) begin
				// equal counts as too low
				if (current_ma_s1 > target_current_q) begin
					if (width_now_q >= width_floor_q) begin
						width_reg = width_now_q - 1'b1;
					end
				end else if (width_now_q <= width_ceiling_q) begin
					width_reg = width_now_q + 1'b1;
				end
				start       = 1'b1;
				width_now_d = width_reg;
			end
			ms_divider_d = div_base - 1'b1;
			if (ms_ev) begin
				phase_timer_d = timer_dec;
				unique case (seq_q)
					SEQ_INIT: begin
						cycles_left_d = min_cycles_q;
						seq_d         = SEQ_PREPARE;
					end
					SEQ_PREPARE: begin
						if (cycles_left_q != '0) begin
							cycles_left_d = cycles_left_q - 1'b1;
						end
						booster_on_d  = 1'b1;
						width_now_d   = width_start_q;
						phase_timer_d = on_time_ms_q;
						seq_d         = SEQ_ON;
					end
					SEQ_ON: begin
						if (timer_dec == '0) begin
							booster_on_d  = 1'b0;
							width_now_d   = width_start_q;
							phase_timer_d = off_time_ms_q;
							seq_d         = SEQ_OFF;
						end
					end
					SEQ_OFF: begin
						if (switch_off_s1 && cycles_left_q == '0) begin
							sleeping_d = 1'b1;
						end else if (timer_dec == '0) begin
							seq_d = SEQ_PREPARE;
						end
					end
					default: ;
				endcase
			end
		end
	end

	logic process;
	assign process = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			booster_on_q  <= 1'b0;
			width_now_q   <= WIDTH_START_RST;
			ms_divider_q  <= '0;
			phase_timer_q <= '0;
			seq_q         <= SEQ_INIT;
			cycles_left_q <= '0;
			sleeping_q    <= 1'b0;
		end else if (process) begin
			booster_on_q  <= booster_on_d;
			width_now_q   <= width_now_d;
			ms_divider_q  <= ms_divider_d;
			phase_timer_q <= phase_timer_d;
			seq_q         <= seq_d;
			cycles_left_q <= cycles_left_d;
			sleeping_q    <= sleeping_d;
		end
	end

	// result register
	logic               pulse_start_s2;
	logic [WIDTH_W-1:0] pulse_width_s2;
	logic               led_phase_on_s2;
	logic               asleep_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			pulse_start_s2  <= start;
			pulse_width_s2  <= start ? width_reg : '0;
			led_phase_on_s2 <= (seq_d == SEQ_ON);
			asleep_s2       <= sleeping_d;
		end
	end

	assign result.valid        = valid_s2;
	assign result.pulse_start  = pulse_start_s2;
	assign result.pulse_width  = pulse_width_s2;
	assign result.led_phase_on = led_phase_on_s2;
	assign result.asleep       = asleep_s2;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the LED flash current regulator: tick stimulus, result checks.
`timescale 1ns / 1ps

module tb
	import lfcr_pkg::*;
();

	typedef struct packed {
		logic               pulse_start;
		logic [WIDTH_W-1:0] pulse_width;
		logic               led_phase_on;
		logic               asleep;
	} flash_result_t;

	// Tracks the regulator state tick by tick and holds the results still owed.
	class flash_scoreboard;
		logic [CUR_W-1:0]   cfg_target;
		logic [WIDTH_W-1:0] cfg_start, cfg_floor, cfg_ceiling;
		logic [DIV_W-1:0]   cfg_ticks;
		logic [TIME_W-1:0]  cfg_on, cfg_off;
		logic [CYC_W-1:0]   cfg_min_cycles;

		logic               boost_en;
		logic               in_sleep;
		logic [WIDTH_W-1:0] width_cur;
		logic [DIV_W-1:0]   ms_count;
		logic [TIME_W-1:0]  phase_left;
		logic [CYC_W-1:0]   cycles_due;
		seq_state_t         seq;

		flash_result_t      expected_results[$];
		int                 errors;

		function new();
			cfg_target     = TARGET_CURRENT_RST;
			cfg_start      = WIDTH_START_RST;
			cfg_floor      = WIDTH_FLOOR_RST;
			cfg_ceiling    = WIDTH_CEILING_RST;
			cfg_ticks      = TICKS_PER_MS_RST;
			cfg_on         = ON_TIME_MS_RST;
			cfg_off        = OFF_TIME_MS_RST;
			cfg_min_cycles = MIN_CYCLES_RST;
			boost_en   = 1'b0;
			in_sleep   = 1'b0;
			width_cur  = WIDTH_START_RST;
			ms_count   = '0;
			phase_left = '0;
			cycles_due = '0;
			seq        = SEQ_INIT;
			errors     = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [REG_DATA_W-1:0] d);
			case (idx)
			REG_TARGET_CURRENT: cfg_target     = d[CUR_W-1:0];
			REG_WIDTH_START:    cfg_start      = d[WIDTH_W-1:0];
			REG_WIDTH_FLOOR:    cfg_floor      = d[WIDTH_W-1:0];
			REG_WIDTH_CEILING:  cfg_ceiling    = d[WIDTH_W-1:0];
			REG_TICKS_PER_MS:   cfg_ticks      = d[DIV_W-1:0];
			REG_ON_TIME_MS:     cfg_on         = d;
			REG_OFF_TIME_MS:    cfg_off        = d;
			REG_MIN_CYCLES:     cfg_min_cycles = d[CYC_W-1:0];
			default: ;
			endcase
		endfunction

		function void switch_boost(logic on);
			boost_en  = on;
			width_cur = cfg_start;
		endfunction

		function void ms_tick(logic off_req);
			if (phase_left != 0)
				phase_left--;
			case (seq)
			SEQ_INIT: begin
				cycles_due = cfg_min_cycles;
				seq = SEQ_PREPARE;
			end
			SEQ_PREPARE: begin
				if (cycles_due != 0)
					cycles_due--;
				switch_boost(1'b1);
				phase_left = cfg_on;
				seq = SEQ_ON;
			end
			SEQ_ON: begin
				if (phase_left == 0) begin
					switch_boost(1'b0);
					phase_left = cfg_off;
					seq = SEQ_OFF;
				end
			end
			default: begin
				// sleep entry leaves the rest of the off-phase check for the wake tick
				if (off_req && cycles_due == 0)
					in_sleep = 1'b1;
				else if (phase_left == 0)
					seq = SEQ_PREPARE;
			end
			endcase
		endfunction

		function void note_tick(logic [CUR_W-1:0] cur, logic off_req);
			flash_result_t r;
			logic ev;
			r = '0;
			if (in_sleep) begin
				if (!off_req) begin
					in_sleep = 1'b0;
					cycles_due = cfg_min_cycles;
					if (phase_left == 0)
						seq = SEQ_PREPARE;
				end
			end else begin
				if (boost_en) begin
					// equal current counts as too low; steps wrap at 8 bits
					if (cur > cfg_target) begin
						if (width_cur >= cfg_floor)
							width_cur = width_cur - 8'd1;
					end else if (width_cur <= cfg_ceiling) begin
						width_cur = width_cur + 8'd1;
					end
					r.pulse_start = 1'b1;
					r.pulse_width = width_cur;
				end
				ev = (ms_count == 0);
				if (ev)
					ms_count = cfg_ticks;
				ms_count = ms_count - 8'd1;
				if (ev)
					ms_tick(off_req);
			end
			r.led_phase_on = (seq == SEQ_ON);
			r.asleep = in_sleep;
			expected_results.push_back(r);
		endfunction

		function void check_result(flash_result_t got);
			flash_result_t exp_r;
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: %p", got);
				errors++;
				return;
			end
			exp_r = expected_results.pop_front();
			if (got.pulse_start !== exp_r.pulse_start) begin
				$error("pulse_start: expected %0d, got %0d", exp_r.pulse_start, got.pulse_start);
				errors++;
			end
			if (got.pulse_width !== exp_r.pulse_width) begin
				$error("pulse_width: expected %0d, got %0d", exp_r.pulse_width, got.pulse_width);
				errors++;
			end
			if (got.led_phase_on !== exp_r.led_phase_on) begin
				$error("led_phase_on: expected %0d, got %0d", exp_r.led_phase_on,
					got.led_phase_on);
				errors++;
			end
			if (got.asleep !== exp_r.asleep) begin
				$error("asleep: expected %0d, got %0d", exp_r.asleep, got.asleep);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	reg_idx_t              wr_index;
	logic [REG_DATA_W-1:0] wr_data;

	lfcr_tick_if   tick ();
	lfcr_result_if result ();

	flash_scoreboard sb = new();

	logic [REG_DATA_W-1:0] cfg [8];
	bit   idle_on;
	bit   hold_off_req;
	logic off_level;
	int   off_run;
	bit   dir_high;
	int   dir_run;

	led_flash_current_regulator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(2_000_000);
		$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			sb.check_result({result.pulse_start, result.pulse_width, result.led_phase_on,
				result.asleep});
	end

	// Receiver: random stall bursts, runs of readiness, and one long hold-off on request.
	initial begin
		int stall_left;
		int run_left;
		stall_left = 0;
		run_left = 0;
		result.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = 80;
			end else if (stall_left == 0 && run_left == 0) begin
				if (idle_on && $urandom_range(0, 2) == 0)
					stall_left = $urandom_range(1, 17);
				else
					run_left = $urandom_range(1, 30);
			end
			if (stall_left != 0) begin
				result.ready <= 1'b0;
				stall_left--;
			end else begin
				result.ready <= 1'b1;
				if (run_left != 0)
					run_left--;
			end
		end
	end

	function automatic int clip(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	task automatic send_tick(input logic [CUR_W-1:0] cur, input logic off);
		tick.valid      <= 1'b1;
		tick.current_ma <= cur;
		tick.switch_off <= off;
		do
			@(posedge clk);
		while (!tick.ready);
		sb.note_tick(cur, off);
		@(negedge clk);
	endtask

	// Currents run in bursts either side of the setpoint; power-off requests come in runs.
	task automatic next_stimulus(output logic [CUR_W-1:0] cur, output logic off);
		int c;
		if (off_run == 0) begin
			off_level = ($urandom_range(0, 99) < 35);
			off_run = $urandom_range(1, 25);
		end
		off_run--;
		if (dir_run == 0) begin
			dir_high = 1'($urandom_range(0, 1));
			dir_run = $urandom_range(1, 20);
		end
		dir_run--;
		if ($urandom_range(0, 7) == 0)
			c = $urandom_range(0, 1023);
		else if (dir_high)
			c = int'(sb.cfg_target) + int'($urandom_range(1, 8));
		else
			c = int'(sb.cfg_target) - int'($urandom_range(0, 8));
		cur = CUR_W'(clip(c, 0, 1023));
		off = off_level;
	endtask

	task automatic run_phase(input int n, input bit idling);
		logic [CUR_W-1:0] cur;
		logic off;
		idle_on = idling;
		repeat (n) begin
			if (idling && $urandom_range(0, 5) == 0) begin
				tick.valid <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
			next_stimulus(cur, off);
			send_tick(cur, off);
		end
	endtask

	task automatic wait_idle();
		tick.valid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic program_regs();
		for (int i = 0; i < 8; i++) begin
			wr_en    <= 1'b1;
			wr_index <= reg_idx_t'(i);
			wr_data  <= cfg[i];
			@(posedge clk);
			sb.write_reg(reg_idx_t'(i), cfg[i]);
			@(negedge clk);
		end
		wr_en <= 1'b0;
	endtask

	task automatic pick_small_cfg();
		int s;
		s = $urandom_range(0, 255);
		cfg[REG_TARGET_CURRENT] = REG_DATA_W'($urandom_range(0, 1023));
		cfg[REG_WIDTH_START]    = REG_DATA_W'(s);
		cfg[REG_WIDTH_FLOOR]    = REG_DATA_W'(clip(s - int'($urandom_range(0, 6)), 1, 255));
		cfg[REG_WIDTH_CEILING]  = REG_DATA_W'(clip(s + int'($urandom_range(0, 6)), 0, 254));
		cfg[REG_TICKS_PER_MS]   = REG_DATA_W'($urandom_range(1, 4));
		cfg[REG_ON_TIME_MS]     = REG_DATA_W'($urandom_range(0, 4));
		cfg[REG_OFF_TIME_MS]    = REG_DATA_W'($urandom_range(0, 4));
		cfg[REG_MIN_CYCLES]     = REG_DATA_W'($urandom_range(0, 3));
	endtask

	initial begin
		logic [CUR_W-1:0] dir_cur [12];
		logic             dir_off [12];
		dir_cur = '{10'd512, 10'd513, 10'd511, 10'd0, 10'd1023, 10'd1023,
			10'd1023, 10'd0, 10'd0, 10'd0, 10'd512, 10'd1023};
		dir_off = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
		arst_n          = 1'b0;
		tick.valid      = 1'b0;
		tick.current_ma = '0;
		tick.switch_off = 1'b0;
		wr_en           = 1'b0;
		wr_index        = REG_TARGET_CURRENT;
		wr_data         = '0;
		idle_on         = 1'b1;
		hold_off_req    = 1'b0;
		off_level       = 1'b0;
		off_run         = 0;
		dir_high        = 1'b0;
		dir_run         = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults; 75 ticks leaves the ms divider at zero, no sleep possible yet
		run_phase(75, 1'b1);

		wait_idle();
		cfg[REG_TARGET_CURRENT] = 16'd512;
		cfg[REG_WIDTH_START]    = 16'd100;
		cfg[REG_WIDTH_FLOOR]    = 16'd145;
		cfg[REG_WIDTH_CEILING]  = 16'd155;
		cfg[REG_TICKS_PER_MS]   = 16'd1;
		cfg[REG_ON_TIME_MS]     = 16'd2;
		cfg[REG_OFF_TIME_MS]    = 16'd1;
		cfg[REG_MIN_CYCLES]     = 16'd1;
		program_regs();
		for (int i = 0; i < 12; i++)
			send_tick(dir_cur[i], dir_off[i]);

		for (int p = 0; p < 11; p++) begin
			wait_idle();
			pick_small_cfg();
			case (p)
			3: begin
				// floor of 0 and ceiling of 255 let the width wrap both ways
				cfg[REG_WIDTH_START]   = $urandom_range(0, 1) ? 16'd255 : 16'd0;
				cfg[REG_WIDTH_FLOOR]   = 16'd0;
				cfg[REG_WIDTH_CEILING] = 16'd255;
				cfg[REG_TICKS_PER_MS]  = 16'd1;
				cfg[REG_ON_TIME_MS]    = REG_DATA_W'($urandom_range(3, 8));
			end
			6: cfg[REG_TICKS_PER_MS] = 16'd0;
			8: begin
				cfg[REG_TARGET_CURRENT] = 16'd0;
				cfg[REG_WIDTH_START]    = 16'd0;
				cfg[REG_WIDTH_FLOOR]    = 16'd1;
				cfg[REG_WIDTH_CEILING]  = 16'd0;
				cfg[REG_TICKS_PER_MS]   = 16'd1;
				cfg[REG_ON_TIME_MS]     = 16'd0;
				cfg[REG_OFF_TIME_MS]    = 16'd0;
				cfg[REG_MIN_CYCLES]     = 16'd0;
			end
			default: ;
			endcase
			program_regs();
			if (p == 5)
				hold_off_req = 1'b1;
			run_phase((p == 6) ? 260 : 80, (p != 5) && ($urandom_range(0, 3) != 0));
		end

		// top of every range but the width ceiling (254), no idling from here on
		wait_idle();
		cfg[REG_TARGET_CURRENT] = 16'd1023;
		cfg[REG_WIDTH_START]    = 16'd255;
		cfg[REG_WIDTH_FLOOR]    = 16'd255;
		cfg[REG_WIDTH_CEILING]  = 16'd254;
		cfg[REG_TICKS_PER_MS]   = 16'd255;
		cfg[REG_ON_TIME_MS]     = 16'hFFFF;
		cfg[REG_OFF_TIME_MS]    = 16'hFFFF;
		cfg[REG_MIN_CYCLES]     = 16'd255;
		program_regs();
		run_phase(100, 1'b0);

		wait_idle();
		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/lfcr_pkg.sv
hw/rtl/lfcr_if.sv
hw/rtl/led_flash_current_regulator.sv
tb/tb.sv
